>>> hw/rtl/nsrf_pkg.sv
// nsrf_pkg: action codes, framing characters, status struct and hex helper
// for the nmea sentence ring framer; no dependencies
`default_nettype none

package nsrf_pkg;

   typedef enum logic [2:0] {
      ACT_BEGIN  = 3'd0,
      ACT_CHAR   = 3'd1,
      ACT_SEP    = 3'd2,
      ACT_FINISH = 3'd3,
      ACT_READ   = 3'd4
   } action_type;

   localparam logic [7:0] CHAR_START = 8'h24;  // '$'
   localparam logic [7:0] CHAR_SEP   = 8'h2C;  // ','
   localparam logic [7:0] CHAR_STAR  = 8'h2A;  // '*'
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_HEX_A = 8'h41;  // 'A'
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   typedef struct packed {
      logic       accepted;
      logic       byte_valid;
      logic [7:0] pending_length;
      logic [7:0] committed_count;
   } rsp_status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [3:0] v;
      v = n & NIBBLE_MASK;
      if (v < 4'd10) begin
         return CHAR_ZERO + 8'(v);
      end else begin
         return CHAR_HEX_A + 8'(v - 4'd10);
      end
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nmea_sentence_ring_framer.sv
// nmea_sentence_ring_framer: each word but a finish has its result registered for the
// next cycle, one word per cycle while req_stall is low; a finish holds req_stall and
// writes one framing byte per cycle through the single ring write port while the
// output is free, then gives its result. reset clears the pointers, checksum and
// result valid; ring contents are not cleared and need no clearing pass, since only
// committed bytes are ever read. depends on nsrf_pkg, nsrf_ctrl and nsrf_ring
`default_nettype none

module nmea_sentence_ring_framer #(
   parameter int RING_DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_action,
   input  wire logic [7:0] req_data_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_accepted,
   output logic            rsp_byte_valid,
   output logic [7:0]      rsp_byte_out,
   output logic [7:0]      rsp_pending_length,
   output logic [7:0]      rsp_committed_count
);

   localparam int PW = $clog2(RING_DEPTH);

   nsrf_pkg::rsp_status_type status;
   logic                     mem_wr_en;
   logic [PW-1:0]            mem_wr_addr;
   logic [7:0]               mem_wr_data;
   logic                     mem_rd_en;
   logic [PW-1:0]            mem_rd_addr;
   logic [7:0]               mem_rd_data;

   nsrf_ctrl #(
      .RING_DEPTH(RING_DEPTH),
      .PW        (PW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_data_char(req_data_char),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (status),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr)
   );

   nsrf_ring #(
      .DEPTH(RING_DEPTH),
      .PW   (PW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   assign rsp_accepted        = status.accepted;
   assign rsp_byte_valid      = status.byte_valid;
   assign rsp_byte_out        = status.byte_valid ? mem_rd_data : 8'h00;
   assign rsp_pending_length  = status.pending_length;
   assign rsp_committed_count = status.committed_count;

endmodule

`default_nettype wire

>>> hw/rtl/nsrf_ring.sv
// nsrf_ring: byte ring storage, one write port and one registered read port
// no package dependencies
`default_nettype none

module nsrf_ring #(
   parameter int DEPTH = 256,
   parameter int PW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [PW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [PW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] ring_mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/nsrf_ctrl.sv
// nsrf_ctrl: ring pointers, running checksum, finish sequencer and result register
// depends on nsrf_pkg
`default_nettype none

module nsrf_ctrl #(
   parameter int RING_DEPTH = 256,
   parameter int PW         = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [2:0]             req_action,
   input  wire logic [7:0]             req_data_char,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output nsrf_pkg::rsp_status_type    rsp_status,
   output logic                        mem_wr_en,
   output logic [PW-1:0]               mem_wr_addr,
   output logic [7:0]                  mem_wr_data,
   output logic                        mem_rd_en,
   output logic [PW-1:0]               mem_rd_addr
);

   localparam int CW = (PW > 8) ? PW : 8;
   localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);
   localparam logic [PW:0]   DEPTH_W   = (PW + 1)'(RING_DEPTH);

   typedef enum logic [2:0] {
      FIN_IDLE,
      FIN_HI,
      FIN_LO,
      FIN_CR,
      FIN_LF
   } fin_state_type;

   fin_state_type            fin_state_ff, fin_state_in;
   logic [PW-1:0]            head_ff, head_in;
   logic [PW-1:0]            front_ff, front_in;
   logic [PW-1:0]            tail_ff, tail_in;
   logic [7:0]               xor_ff, xor_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   nsrf_pkg::rsp_status_type status_ff, status_in;

   logic       out_free;
   logic       take;
   logic       put_en;
   logic [7:0] put_byte;
   logic       put_ok;
   logic       load;
   logic       do_commit;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [7:0] ring_dist8(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
      logic [PW:0]   t;
      logic [CW-1:0] e;
      t = {1'b0, a} - {1'b0, b};
      if (a < b) begin
         t = t + DEPTH_W;
      end
      e = CW'(t[PW-1:0]);
      return e[7:0];
   endfunction

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (fin_state_ff != FIN_IDLE) || !out_free;
      take      = req_valid && !req_stall;

      fin_state_in = fin_state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      xor_in       = xor_ff;
      status_in    = status_ff;
      put_en       = 1'b0;
      put_byte     = nsrf_pkg::CHAR_START;
      load         = 1'b0;
      do_commit    = 1'b0;
      mem_rd_en    = 1'b0;
      status_in.accepted   = 1'b0;
      status_in.byte_valid = 1'b0;

      // finish sequence: the remaining four framing bytes
      case (fin_state_ff)
         FIN_HI: begin
            put_en       = 1'b1;
            put_byte     = nsrf_pkg::hex_digit(xor_ff[7:4]);
            fin_state_in = FIN_LO;
         end
         FIN_LO: begin
            put_en       = 1'b1;
            put_byte     = nsrf_pkg::hex_digit(xor_ff[3:0]);
            fin_state_in = FIN_CR;
         end
         FIN_CR: begin
            put_en       = 1'b1;
            put_byte     = nsrf_pkg::CHAR_CR;
            fin_state_in = FIN_LF;
         end
         FIN_LF: begin
            put_byte = nsrf_pkg::CHAR_LF;
            if (out_free) begin
               put_en       = 1'b1;
               do_commit    = 1'b1;
               load         = 1'b1;
               fin_state_in = FIN_IDLE;
               status_in.accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (take) begin
         case (req_action)
            nsrf_pkg::ACT_BEGIN: begin
               put_en   = 1'b1;
               put_byte = nsrf_pkg::CHAR_START;
               load     = 1'b1;
            end
            nsrf_pkg::ACT_CHAR: begin
               put_en   = 1'b1;
               put_byte = req_data_char;
               load     = 1'b1;
            end
            nsrf_pkg::ACT_SEP: begin
               put_en   = 1'b1;
               put_byte = nsrf_pkg::CHAR_SEP;
               load     = 1'b1;
            end
            nsrf_pkg::ACT_FINISH: begin
               put_en       = 1'b1;
               put_byte     = nsrf_pkg::CHAR_STAR;
               fin_state_in = FIN_HI;
            end
            nsrf_pkg::ACT_READ: begin
               load = 1'b1;
               if (head_ff != tail_ff) begin
                  mem_rd_en            = 1'b1;
                  tail_in              = ring_next(tail_ff);
                  status_in.byte_valid = 1'b1;
               end
            end
            default: begin
               load = 1'b1;
            end
         endcase
      end

      // single ring write, dropped when only one slot is left
      put_ok   = put_en && (ring_next(front_ff) != tail_ff);
      front_in = put_ok ? ring_next(front_ff) : front_ff;

      if (take) begin
         case (req_action)
            nsrf_pkg::ACT_BEGIN: begin
               status_in.accepted = put_ok;
               if (put_ok) begin
                  xor_in = '0;
               end
            end
            nsrf_pkg::ACT_CHAR, nsrf_pkg::ACT_SEP: begin
               status_in.accepted = put_ok;
               if (put_ok) begin
                  xor_in = xor_ff ^ put_byte;
               end
            end
            default: begin
            end
         endcase
      end

      if (do_commit) begin
         head_in = front_in;
      end

      status_in.pending_length  = ring_dist8(front_in, head_ff);
      status_in.committed_count = ring_dist8(head_in, tail_in);

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      mem_wr_en   = put_ok;
      mem_wr_addr = front_ff;
      mem_wr_data = put_byte;
      mem_rd_addr = tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_state_ff <= FIN_IDLE;
         head_ff      <= '0;
         front_ff     <= '0;
         tail_ff      <= '0;
         xor_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fin_state_ff <= fin_state_in;
         head_ff      <= head_in;
         front_ff     <= front_in;
         tail_ff      <= tail_in;
         xor_ff       <= xor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

>>> tb/nmea_sentence_ring_framer_tb.sv
// nmea_sentence_ring_framer_tb: self-checking bench for the nmea sentence ring framer
// directed and random action words are checked against a built-in ring and checksum tracker
// depends on nsrf_pkg and nmea_sentence_ring_framer
`timescale 1ns / 1ps

module nmea_sentence_ring_framer_tb;

   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] data_char;
   } ring_word_type;

   typedef struct packed {
      logic       accepted;
      logic       byte_valid;
      logic [7:0] byte_out;
      logic [7:0] pending_length;
      logic [7:0] committed_count;
   } ring_reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_action = nsrf_pkg::ACT_READ;
   logic [7:0] req_data_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_accepted;
   logic       rsp_byte_valid;
   logic [7:0] rsp_byte_out;
   logic [7:0] rsp_pending_length;
   logic [7:0] rsp_committed_count;

   // tracked ring state
   logic [7:0] ring_mem [256];
   logic [7:0] ring_head = 8'd0;
   logic [7:0] ring_front = 8'd0;
   logic [7:0] ring_tail = 8'd0;
   logic [7:0] ring_xor = 8'd0;

   ring_word_type  action_words [$];
   ring_reply_type ring_replies [$];
   ring_word_type  drive_word;
   ring_reply_type predicted;
   ring_reply_type arrived;
   logic           req_fire = 1'b0;
   int             send_gap_pct = 0;
   int             rsp_stall_pct = 0;
   int             fail_count = 0;
   int             words_taken = 0;
   int             sentences_closed = 0;
   int             bytes_read = 0;
   int             bytes_refused = 0;

   nmea_sentence_ring_framer #(
      .RING_DEPTH(256)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_data_char      (req_data_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_pending_length (rsp_pending_length),
      .rsp_committed_count(rsp_committed_count)
   );

   initial forever #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("nmea_sentence_ring_framer_tb NOT OK");
      $finish;
   end

   function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
      if (n < 4'd10) begin
         return nsrf_pkg::CHAR_ZERO + 8'(n);
      end
      return nsrf_pkg::CHAR_HEX_A + 8'(n) - 8'd10;
   endfunction

   // one slot stays free, a byte that does not fit is dropped
   function automatic bit ring_push(input logic [7:0] b);
      if (ring_front + 8'd1 == ring_tail) begin
         return 1'b0;
      end
      ring_mem[ring_front] = b;
      ring_front = ring_front + 8'd1;
      return 1'b1;
   endfunction

   function automatic ring_reply_type ring_action(input logic [2:0] act, input logic [7:0] ch);
      ring_reply_type r;
      logic [7:0]     b;
      r = '0;
      case (act)
         nsrf_pkg::ACT_BEGIN: begin
            if (ring_push(nsrf_pkg::CHAR_START)) begin
               ring_xor = 8'd0;
               r.accepted = 1'b1;
            end
         end
         nsrf_pkg::ACT_CHAR, nsrf_pkg::ACT_SEP: begin
            b = (act == nsrf_pkg::ACT_CHAR) ? ch : nsrf_pkg::CHAR_SEP;
            if (ring_push(b)) begin
               ring_xor = ring_xor ^ b;
               r.accepted = 1'b1;
            end
         end
         nsrf_pkg::ACT_FINISH: begin
            void'(ring_push(nsrf_pkg::CHAR_STAR));
            void'(ring_push(nibble_ascii(ring_xor[7:4])));
            void'(ring_push(nibble_ascii(ring_xor[3:0])));
            void'(ring_push(nsrf_pkg::CHAR_CR));
            void'(ring_push(nsrf_pkg::CHAR_LF));
            r.accepted = 1'b1;
         end
         nsrf_pkg::ACT_READ: begin
            if (ring_head != ring_tail) begin
               r.byte_valid = 1'b1;
               r.byte_out = ring_mem[ring_tail];
               ring_tail = ring_tail + 8'd1;
            end
         end
         default: begin
         end
      endcase
      r.pending_length = ring_front - ring_head;
      if (act == nsrf_pkg::ACT_FINISH) begin
         ring_head = ring_front;
      end
      r.committed_count = ring_head - ring_tail;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic add_word(input logic [2:0] act, input logic [7:0] ch);
      action_words.push_back('{act, ch});
   endtask

   function automatic logic [7:0] pick_char();
      if ($urandom_range(99) < 25) begin
         return 8'($urandom);
      end
      return 8'($urandom_range(32, 126));
   endfunction

   task automatic add_sentence(input int max_chars);
      int n;
      n = ($urandom_range(99) < 5) ? $urandom_range(0, 40) : $urandom_range(0, max_chars);
      add_word(nsrf_pkg::ACT_BEGIN, 8'($urandom));
      repeat (n) begin
         if ($urandom_range(99) < 20) begin
            add_word(nsrf_pkg::ACT_SEP, 8'($urandom));
         end else begin
            add_word(nsrf_pkg::ACT_CHAR, pick_char());
         end
      end
      add_word(nsrf_pkg::ACT_FINISH, 8'($urandom));
   endtask

   task automatic queue_random(input int n_words, input int read_pct, input int read_len,
                               input int max_chars);
      int r;
      while (action_words.size() < n_words) begin
         r = $urandom_range(99);
         if (r < read_pct) begin
            repeat ($urandom_range(1, read_len)) add_word(nsrf_pkg::ACT_READ, 8'($urandom));
         end else if (r < read_pct + 8) begin
            add_word(3'($urandom), 8'($urandom));
         end else if (r < read_pct + 16) begin
            // broken framing: open sentence left unfinished, or stray finish / separator
            case ($urandom_range(2))
               0: begin
                  add_word(nsrf_pkg::ACT_BEGIN, 8'($urandom));
                  repeat ($urandom_range(0, 3)) add_word(nsrf_pkg::ACT_CHAR, pick_char());
               end
               1: add_word(nsrf_pkg::ACT_FINISH, 8'($urandom));
               default: add_word(nsrf_pkg::ACT_SEP, 8'($urandom));
            endcase
         end else begin
            add_sentence(max_chars);
         end
      end
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (action_words.size() != 0 || req_valid || ring_replies.size() != 0);
   endtask

   task automatic run_phase(input int gap_pct, input int stall_pct, input int n_words,
                            input int read_pct, input int read_len, input int max_chars);
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      queue_random(n_words, read_pct, read_len, max_chars);
      wait_drained();
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (action_words.size() == 0 || $urandom_range(99) < send_gap_pct) begin
            req_valid <= 1'b0;
         end else begin
            drive_word = action_words.pop_front();
            req_valid <= 1'b1;
            req_action <= drive_word.action;
            req_data_char <= drive_word.data_char;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         predicted = ring_action(req_action, req_data_char);
         ring_replies.push_back(predicted);
         words_taken++;
         if (req_action == nsrf_pkg::ACT_FINISH) begin
            sentences_closed++;
         end
         if (predicted.byte_valid) begin
            bytes_read++;
         end
         if (req_action <= nsrf_pkg::ACT_SEP && !predicted.accepted) begin
            bytes_refused++;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ring_replies.size() == 0) begin
            $error("result word with nothing outstanding");
            fail_count++;
         end else begin
            arrived = ring_replies.pop_front();
            check_field("accepted", 8'(arrived.accepted), 8'(rsp_accepted));
            check_field("byte_valid", 8'(arrived.byte_valid), 8'(rsp_byte_valid));
            check_field("byte_out", arrived.byte_out, rsp_byte_out);
            check_field("pending_length", arrived.pending_length, rsp_pending_length);
            check_field("committed_count", arrived.committed_count, rsp_committed_count);
         end
      end
   end

   initial begin
      int a;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // read on empty, spare codes, framing extremes, begin over a pending sentence
      add_word(nsrf_pkg::ACT_READ, 8'hFF);
      for (a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) begin
         add_word(3'(a), 8'hFF);
      end
      add_word(nsrf_pkg::ACT_BEGIN, 8'h00);
      add_word(nsrf_pkg::ACT_CHAR, 8'h00);
      add_word(nsrf_pkg::ACT_CHAR, 8'hFF);
      add_word(nsrf_pkg::ACT_SEP, 8'h55);
      add_word(nsrf_pkg::ACT_CHAR, 8'h47);
      add_word(nsrf_pkg::ACT_CHAR, 8'hAA);
      add_word(nsrf_pkg::ACT_FINISH, 8'h00);
      repeat (3) add_word(nsrf_pkg::ACT_READ, 8'h00);
      add_word(nsrf_pkg::ACT_BEGIN, 8'hFF);
      add_word(nsrf_pkg::ACT_CHAR, 8'h78);
      add_word(nsrf_pkg::ACT_BEGIN, 8'hFF);
      add_word(nsrf_pkg::ACT_CHAR, 8'h79);
      add_word(nsrf_pkg::ACT_SEP, 8'h00);
      add_word(nsrf_pkg::ACT_FINISH, 8'hFF);
      repeat (2) add_word(nsrf_pkg::ACT_READ, 8'hFF);
      wait_drained();

      run_phase(0, 0, 140, 3, 4, 3);
      run_phase(74, 0, 110, 55, 30, 8);
      run_phase(0, 74, 140, 4, 4, 2);
      run_phase(29, 29, 100, 30, 16, 10);

      repeat (10) @(posedge clock);
      $display("ran %0d action words under four idle/stall mixes: %0d sentences closed,",
               words_taken, sentences_closed);
      $display("%0d bytes read back, %0d writes refused on a full ring",
               bytes_read, bytes_refused);
      if (fail_count == 0) begin
         $display("nmea_sentence_ring_framer_tb OK");
      end else begin
         $display("nmea_sentence_ring_framer_tb NOT OK");
      end
      $finish;
   end

endmodule
